### rtl/jdq_pkg.sv
// Shared types, constants and helper functions for the job dispatch queue.
package jdq_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 16;
    localparam int OCC_W       = 5;

    // Request kinds.
    localparam logic FUNC_INSERT   = 1'b0;
    localparam logic FUNC_DISPATCH = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_INSERTED   = 2'd0;
    localparam logic [1:0] ST_DISPATCHED = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;
    localparam logic [1:0] ST_EMPTY      = 2'd3;

    // Dispatch policies; the unused code behaves as first-come.
    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_SJF  = 2'd1;
    localparam logic [1:0] POL_PRIO = 2'd2;

    // One stored job.
    typedef struct packed {
        logic [15:0] job_id;
        logic [15:0] run_time;
        logic [7:0]  prio_level;
    } t_entry;

    // Search token that walks down the chain of cells.
    typedef struct packed {
        logic             vld;
        logic             found;
        logic [IDX_W-1:0] idx;
        t_entry           entry;
    } t_token;

    // Control group broadcast from the top level to every cell.
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [IDX_W-1:0] rem_idx;
        logic [CNT_W-1:0] count;
        logic [1:0]       policy;
    } t_cell_ctl;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } t_state;

    // Sort key of an entry under the given policy; first-come uses a constant key
    // so that the earliest arrival always wins.
    function automatic logic [KEY_W-1:0] entry_key(input t_entry e, input logic [1:0] pol);
        logic [KEY_W-1:0] k;
        case (pol)
            POL_SJF:  k = e.run_time;
            POL_PRIO: k = {{(KEY_W - 8){1'b0}}, e.prio_level};
            default:  k = '0;
        endcase
        return k;
    endfunction

endpackage

### rtl/job_dispatch_queue.sv
// Insert, reject and empty results are captured at the request transfer and loaded from the finish state.
// A dispatch runs a search token down all TABLE_DEPTH cells, one cell per cycle,
// and the winning job is captured at the end of the search and loaded from the finish state.
// One request is in flight at a time: the request channel stalls until the result is loaded,
// so a stalled result keeps new requests waiting.
// Synchronous active-low reset empties the table, selects first-come and clears handshake state.
module job_dispatch_queue
    import jdq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Request channel.
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_func,
    input  logic [15:0]      i_job_id,
    input  logic [15:0]      i_run_time,
    input  logic [7:0]       i_prio_level,
    // Result channel.
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [1:0]       o_status,
    output logic [15:0]      o_out_job_id,
    output logic [15:0]      o_out_run_time,
    output logic [7:0]       o_out_prio_level,
    output logic [OCC_W-1:0] o_occupancy,
    // Policy register write channel.
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_policy
);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [1:0]       r_policy;
    logic             r_start;
    logic [1:0]       r_res_status;
    t_entry           r_res_entry;
    logic             r_out_valid;
    logic [1:0]       r_status;
    t_entry           r_out_entry;
    logic [OCC_W-1:0] r_occupancy;

    logic             in_xfer;
    logic             is_full;
    logic             is_empty;
    logic             out_free;
    logic             load_out;
    t_cell_ctl        ctl;
    t_entry           ins_entry;
    t_token           tok_in  [TABLE_DEPTH];
    t_token           tok_out [TABLE_DEPTH];
    t_entry           cell_entry [TABLE_DEPTH];
    t_entry           next_entry [TABLE_DEPTH];
    t_token           last_tok;
    logic [CNT_W+OCC_W-1:0] occ_ext;

    assign in_xfer   = i_in_valid && !o_in_stall;
    assign is_full   = r_count == CNT_W'(TABLE_DEPTH);
    assign is_empty  = r_count == '0;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign last_tok  = tok_out[TABLE_DEPTH-1];
    assign ins_entry = '{job_id: i_job_id, run_time: i_run_time, prio_level: i_prio_level};

    // Next-state logic of the request sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if ((i_func == FUNC_DISPATCH) && !is_empty) begin
                        n_state = S_SEARCH;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_SEARCH: begin
                if (last_tok.vld) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs toward the cells and the result register.
    always_comb begin
        o_in_stall  = r_state != S_IDLE;
        load_out    = (r_state == S_FINISH) && out_free;
        ctl.ins     = in_xfer && (i_func == FUNC_INSERT) && !is_full;
        ctl.rem     = (r_state == S_SEARCH) && last_tok.vld;
        ctl.rem_idx = last_tok.idx;
        ctl.count   = r_count;
        ctl.policy  = r_policy;
    end

    // State, fill count and search launch.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= in_xfer && (i_func == FUNC_DISPATCH) && !is_empty;
            if (ctl.ins) begin
                r_count <= r_count + CNT_W'(1);
            end else if (ctl.rem) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Policy register; the user must write it only while the block is idle, the block itself does not enforce this.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_FIFO;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_policy <= i_cfg_policy;
        end
    end

    // Pending result captured at the transfer or at the end of the search.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_res_entry <= '0;
            if (i_func == FUNC_INSERT) begin
                r_res_status <= is_full ? ST_FULL : ST_INSERTED;
            end else begin
                r_res_status <= ST_EMPTY;
            end
        end else if (ctl.rem) begin
            r_res_status <= ST_DISPATCHED;
            r_res_entry  <= last_tok.entry;
        end
    end

    // Output register; the count has settled by the time the result is loaded.
    assign occ_ext = {{OCC_W{1'b0}}, r_count};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (load_out) begin
            r_status    <= r_res_status;
            r_out_entry <= r_res_entry;
            r_occupancy <= occ_ext[OCC_W-1:0];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_out_job_id     = r_out_entry.job_id;
    assign o_out_run_time   = r_out_entry.run_time;
    assign o_out_prio_level = r_out_entry.prio_level;
    assign o_occupancy      = r_occupancy;

    // Chain of cells in arrival order; the last cell refills from itself.
    always_comb begin
        tok_in[0] = '{vld: r_start, found: 1'b0, idx: '0, entry: '0};
        for (int k = 1; k < TABLE_DEPTH; k++) begin
            tok_in[k] = tok_out[k-1];
        end
        for (int k = 0; k < TABLE_DEPTH - 1; k++) begin
            next_entry[k] = cell_entry[k+1];
        end
        next_entry[TABLE_DEPTH-1] = cell_entry[TABLE_DEPTH-1];
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        jdq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_index      (IDX_W'(g)),
            .i_ctl        (ctl),
            .i_ins_entry  (ins_entry),
            .i_next_entry (next_entry[g]),
            .i_tok        (tok_in[g]),
            .o_tok        (tok_out[g]),
            .o_entry      (cell_entry[g])
        );
    end

endmodule

### rtl/jdq_cell.sv
// One table cell: holds a job, shifts on removal and passes the search token on.
module jdq_cell
    import jdq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_index,
    input  t_cell_ctl        i_ctl,
    input  t_entry           i_ins_entry,
    input  t_entry           i_next_entry,
    input  t_token           i_tok,
    output t_token           o_tok,
    output t_entry           o_entry
);

    t_entry r_entry;
    t_token r_tok;
    t_token n_tok;
    logic   own_valid;
    logic   own_better;

    // A cell holds a job when its place lies below the fill count.
    assign own_valid  = CNT_W'(i_index) < i_ctl.count;
    assign own_better = !i_tok.found ||
                        (entry_key(r_entry, i_ctl.policy) < entry_key(i_tok.entry, i_ctl.policy));

    // Entry storage: an insert lands at the fill count, a removal pulls the neighbor in.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && (CNT_W'(i_index) == i_ctl.count)) begin
            r_entry <= i_ins_entry;
        end else if (i_ctl.rem && (i_index >= i_ctl.rem_idx)) begin
            r_entry <= i_next_entry;
        end
    end

    // Running minimum: keep the incoming best unless this cell is strictly better.
    always_comb begin
        n_tok     = i_tok;
        n_tok.vld = i_tok.vld;
        if (i_tok.vld && own_valid && own_better) begin
            n_tok.found = 1'b1;
            n_tok.idx   = i_index;
            n_tok.entry = r_entry;
        end
    end

    // Token register toward the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= n_tok.vld;
        end
        r_tok.found <= n_tok.found;
        r_tok.idx   <= n_tok.idx;
        r_tok.entry <= n_tok.entry;
    end

    assign o_tok   = r_tok;
    assign o_entry = r_entry;

endmodule

### rtl/jdq_checker.sv
// Port-level checker for the job dispatch queue, bound to the top level.
module jdq_checker
    import jdq_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [1:0]       o_status,
    input logic [15:0]      o_out_job_id,
    input logic [15:0]      o_out_run_time,
    input logic [7:0]       o_out_prio_level,
    input logic [OCC_W-1:0] o_occupancy
);

    localparam logic [CNT_W+OCC_W-1:0] FULL_EXT = (CNT_W + OCC_W)'(TABLE_DEPTH);
    localparam logic [OCC_W-1:0]       OCC_FULL = FULL_EXT[OCC_W-1:0];

    // A stalled result holds its status, job id and occupancy.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) &&
        $stable(o_out_job_id) && $stable(o_occupancy))
        else $error("stalled result changed");

    // Only a dispatched result carries job fields.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_DISPATCHED) |->
        (o_out_job_id == '0) && (o_out_run_time == '0) && (o_out_prio_level == '0))
        else $error("job fields set on a non-dispatch result");

    // An empty report leaves the table empty; a rejection leaves it full.
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_EMPTY) |-> o_occupancy == '0)
        else $error("empty report with jobs held");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) |-> o_occupancy == OCC_FULL)
        else $error("rejection while table not full");

    // After a request transfer the block is busy in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken back to back");

endmodule

bind job_dispatch_queue jdq_checker u_jdq_checker (.*);
